/* hw/rtl/chunk_map_first_fit_allocator_macros.svh */
// ----------------------------------------------------------------------------
// chunk map allocator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CHUNK_MAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define CHUNK_MAP_FIRST_FIT_ALLOCATOR_MACROS_SVH

// same-cycle implication, off during reset
`define CMFF_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("chunk allocator check failed");

// next-cycle implication, off during reset
`define CMFF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("chunk allocator check failed");

// next-cycle implication that also holds through reset
`define CMFF_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("chunk allocator check failed");

`endif

/* hw/rtl/cmff_pkg.sv */
// ----------------------------------------------------------------------------
// cmff_pkg
// constants, codes and types shared by the chunk map allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmff_pkg;
   localparam int MAX_CHUNKS = 1024;
   localparam int IDX_W      = $clog2(MAX_CHUNKS);
   localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
   localparam int MARK_W     = 2;
   localparam int DATA_W     = 32;
   localparam int CHUNK_W    = 16;
   localparam int BYTES_W    = CNT_W + CHUNK_W;
   localparam int CSR_IDX_W  = 8;
   localparam int STATUS_W   = 3;
   localparam int OP_W       = 2;
   localparam int DIV_STEPS  = DATA_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [MARK_W-1:0] MARK_EMPTY    = 2'h0;
   localparam logic [MARK_W-1:0] MARK_BEGIN    = 2'h1;
   localparam logic [MARK_W-1:0] MARK_INTERIOR = 2'h2;
   localparam logic [MARK_W-1:0] MARK_END      = 2'h3;

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OUT_RANGE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_START  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK  = 8'd1;

   localparam logic [DATA_W-1:0]  REGION_RESET = 32'd65536;
   localparam logic [CHUNK_W-1:0] CHUNK_RESET  = 16'd64;

   typedef struct packed {
      logic               done;
      logic [DATA_W-1:0]  quotient;
      logic [CHUNK_W-1:0] remainder;
   } div_res_type;
endpackage

/* hw/rtl/chunk_map_first_fit_allocator.sv */
// ----------------------------------------------------------------------------
// chunk_map_first_fit_allocator
// first-fit allocator over a chunk map of a remote memory region
// ----------------------------------------------------------------------------
// requests enter on req_ (op, request_bytes, release_offset) with valid/ready;
// each gives one response beat on rsp_ with status, granted offset, bytes in
// use and an empty flag. csr_ writes region_bytes (index 0) or chunk_bytes
// (index 1) and empty the map; csr_ready is always high.
// the chunk map is a 1024 x 2 ram with registered read. byte to chunk
// conversion uses a serial divider. allocate scans chunks from the
// first-free hint, then marks the chunks it takes and, if the run began at
// the hint, moves the hint past them. release checks that the offset starts
// an allocation and frees chunks up to its end mark; clear empties the map.
// reset and every csr write start a sweep that empties the map,
// followed by a chunk count; req_ready stays low until both end.
// one item is in flight at a time. the response sits in an output register;
// req_ready returns once it is loaded, and a new item finishing while the
// receiver still stalls waits until that beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chunk_map_first_fit_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cmff_pkg::OP_W-1:0]      req_op,
   input  logic [cmff_pkg::DATA_W-1:0]    req_request_bytes,
   input  logic [cmff_pkg::DATA_W-1:0]    req_release_offset,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cmff_pkg::STATUS_W-1:0]  rsp_status,
   output logic [cmff_pkg::DATA_W-1:0]    rsp_granted_offset,
   output logic [cmff_pkg::DATA_W-1:0]    rsp_used_bytes,
   output logic                          rsp_region_empty,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cmff_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cmff_pkg::DATA_W-1:0]    csr_wdata
);
   import cmff_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_SWEEP  = 12'b000000000010,
      S_COUNT  = 12'b000000000100,
      S_DIVREQ = 12'b000000001000,
      S_ASCAN  = 12'b000000010000,
      S_AMARK  = 12'b000000100000,
      S_AHINT  = 12'b000001000000,
      S_RCHK0  = 12'b000010000000,
      S_RCHK1  = 12'b000100000000,
      S_RWALK  = 12'b001000000000,
      S_ACCUM  = 12'b010000000000,
      S_RESP   = 12'b100000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [DATA_W-1:0]  region_ff, region_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [CNT_W-1:0]   nchunk_ff, nchunk_in;
   logic [CNT_W-1:0]   hint_ff, hint_in;
   logic [DATA_W-1:0]  used_ff, used_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0]  granted_ff, granted_in;
   logic [CNT_W-1:0]   need_ff, need_in;
   logic [CNT_W-1:0]   begin_ff, begin_in;
   logic [CNT_W-1:0]   run_ff, run_in;
   logic [CNT_W-1:0]   iss_ff, iss_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   paddr_ff, paddr_in;
   logic [IDX_W-1:0]   wptr_ff, wptr_in;
   logic [IDX_W-1:0]   last_ff, last_in;
   logic [CNT_W-1:0]   freed_ff, freed_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic               sweep_op_ff, sweep_op_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_granted_ff, rsp_granted_in;
   logic [DATA_W-1:0]  rsp_used_ff, rsp_used_in;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [MARK_W-1:0]  mem_wdata;
   logic [IDX_W-1:0]   mem_raddr;
   logic [MARK_W-1:0]  mem_rdata;

   logic               div_start;
   logic [DATA_W-1:0]  div_dividend;
   div_res_type        div_res;

   logic [CHUNK_W-1:0] chunk_size;
   logic [CNT_W-1:0]   last_idx;
   logic               q_ovf;
   logic [CNT_W:0]     q_ceil;
   logic               rem_nz;
   logic               at_last;
   logic [CNT_W-1:0]   run_new;
   logic [CNT_W-1:0]   begin_new;
   logic [CNT_W-1:0]   freed_new;
   logic [CNT_W-1:0]   idx_ext;

   cmff_ram #(.WIDTH(MARK_W), .DEPTH(MAX_CHUNKS)) u_marks (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   cmff_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (chunk_size),
      .res      (div_res)
   );

   assign chunk_size = (chunk_ff == '0) ? CHUNK_W'(1) : chunk_ff;
   assign last_idx   = nchunk_ff - 1'b1;
   assign q_ovf      = |div_res.quotient[DATA_W-1:CNT_W];
   assign rem_nz     = div_res.remainder != '0;
   assign q_ceil     = {1'b0, div_res.quotient[CNT_W-1:0]} + (CNT_W+1)'(rem_nz);
   assign at_last    = CNT_W'(paddr_ff) == last_idx;
   assign run_new    = (mem_rdata != MARK_EMPTY) ? '0 : run_ff + 1'b1;
   assign begin_new  = (mem_rdata != MARK_EMPTY) ? CNT_W'(paddr_ff) + 1'b1 : begin_ff;
   assign freed_new  = freed_ff + 1'b1;
   assign idx_ext    = CNT_W'(idx_ff);

   always_comb begin
      state_in       = state_ff;
      region_in      = region_ff;
      chunk_in       = chunk_ff;
      nchunk_in      = nchunk_ff;
      hint_in        = hint_ff;
      used_in        = used_ff;
      op_in          = op_ff;
      status_in      = status_ff;
      granted_in     = granted_ff;
      need_in        = need_ff;
      begin_in       = begin_ff;
      run_in         = run_ff;
      iss_in         = iss_ff;
      pend_in        = 1'b0;
      paddr_in       = iss_ff[IDX_W-1:0];
      wptr_in        = wptr_ff;
      last_in        = last_ff;
      freed_in       = freed_ff;
      idx_in         = idx_ff;
      bytes_in       = bytes_ff;
      sweep_op_in    = sweep_op_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_used_in    = rsp_used_ff;
      mem_we         = 1'b0;
      mem_waddr      = wptr_ff;
      mem_wdata      = MARK_EMPTY;
      mem_raddr      = iss_ff[IDX_W-1:0];
      div_start      = 1'b0;
      div_dividend   = region_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               status_in  = ST_OK;
               granted_in = '0;
               case (req_op)
                  OP_ALLOC: begin
                     div_start    = 1'b1;
                     div_dividend = req_request_bytes;
                     state_in     = S_DIVREQ;
                  end
                  OP_RELEASE: begin
                     div_start    = 1'b1;
                     div_dividend = req_release_offset;
                     state_in     = S_DIVREQ;
                  end
                  OP_CLEAR: begin
                     used_in     = '0;
                     hint_in     = '0;
                     wptr_in     = '0;
                     sweep_op_in = 1'b1;
                     state_in    = S_SWEEP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            mem_we  = 1'b1;
            wptr_in = wptr_ff + 1'b1;
            if (wptr_ff == IDX_W'(MAX_CHUNKS - 1)) begin
               if (sweep_op_ff) begin
                  state_in = S_RESP;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_COUNT;
               end
            end
         end
         S_COUNT: begin
            if (div_res.done) begin
               if (q_ovf || q_ceil > (CNT_W+1)'(MAX_CHUNKS)) begin
                  nchunk_in = CNT_W'(MAX_CHUNKS);
               end else begin
                  nchunk_in = q_ceil[CNT_W-1:0];
               end
               state_in = S_IDLE;
            end
         end
         S_DIVREQ: begin
            if (div_res.done) begin
               if (op_ff == OP_ALLOC) begin
                  if (q_ovf || q_ceil == '0 || q_ceil > {1'b0, nchunk_ff} ||
                      hint_ff >= nchunk_ff) begin
                     status_in = ST_NO_SPACE;
                     state_in  = S_RESP;
                  end else begin
                     need_in  = q_ceil[CNT_W-1:0];
                     iss_in   = hint_ff;
                     begin_in = hint_ff;
                     run_in   = '0;
                     state_in = S_ASCAN;
                  end
               end else begin
                  if (rem_nz) begin
                     status_in = ST_MISALIGNED;
                     state_in  = S_RESP;
                  end else if (q_ovf || div_res.quotient[CNT_W-1:0] >= nchunk_ff) begin
                     status_in = ST_OUT_RANGE;
                     state_in  = S_RESP;
                  end else begin
                     mem_raddr = div_res.quotient[IDX_W-1:0];
                     idx_in    = div_res.quotient[IDX_W-1:0];
                     state_in  = S_RCHK0;
                  end
               end
            end
         end
         S_ASCAN: begin
            if (iss_ff < nchunk_ff) begin
               pend_in = 1'b1;
               iss_in  = iss_ff + 1'b1;
            end
            if (pend_ff) begin
               run_in   = run_new;
               begin_in = begin_new;
               if (run_new == need_ff) begin
                  wptr_in  = begin_new[IDX_W-1:0];
                  last_in  = IDX_W'(begin_new + need_ff - 1'b1);
                  state_in = S_AMARK;
               end else if (at_last) begin
                  status_in = ST_NO_SPACE;
                  state_in  = S_RESP;
               end
            end
         end
         S_AMARK: begin
            mem_we  = 1'b1;
            wptr_in = wptr_ff + 1'b1;
            if (wptr_ff == last_ff) begin
               mem_wdata = MARK_END;
            end else if (CNT_W'(wptr_ff) == begin_ff) begin
               mem_wdata = MARK_BEGIN;
            end else begin
               mem_wdata = MARK_INTERIOR;
            end
            if (wptr_ff == last_ff) begin
               granted_in = DATA_W'(BYTES_W'(begin_ff) * BYTES_W'(chunk_size));
               bytes_in   = BYTES_W'(need_ff) * BYTES_W'(chunk_size);
               if (begin_ff == hint_ff) begin
                  if (CNT_W'(last_ff) + 1'b1 >= nchunk_ff) begin
                     hint_in  = nchunk_ff;
                     state_in = S_ACCUM;
                  end else begin
                     iss_in   = CNT_W'(last_ff) + 1'b1;
                     state_in = S_AHINT;
                  end
               end else begin
                  state_in = S_ACCUM;
               end
            end
         end
         S_AHINT: begin
            if (iss_ff < nchunk_ff) begin
               pend_in = 1'b1;
               iss_in  = iss_ff + 1'b1;
            end
            if (pend_ff) begin
               if (mem_rdata == MARK_EMPTY) begin
                  hint_in  = CNT_W'(paddr_ff);
                  state_in = S_ACCUM;
               end else if (at_last) begin
                  hint_in  = nchunk_ff;
                  state_in = S_ACCUM;
               end
            end
         end
         S_RCHK0: begin
            iss_in   = idx_ext;
            freed_in = '0;
            if (mem_rdata == MARK_BEGIN) begin
               state_in = S_RWALK;
            end else if (mem_rdata == MARK_END) begin
               if (idx_ff == '0) begin
                  state_in = S_RWALK;
               end else begin
                  mem_raddr = idx_ff - 1'b1;
                  state_in  = S_RCHK1;
               end
            end else begin
               status_in = ST_NOT_START;
               state_in  = S_RESP;
            end
         end
         S_RCHK1: begin
            if (mem_rdata == MARK_BEGIN || mem_rdata == MARK_INTERIOR) begin
               status_in = ST_NOT_START;
               state_in  = S_RESP;
            end else begin
               state_in = S_RWALK;
            end
         end
         S_RWALK: begin
            if (iss_ff < nchunk_ff) begin
               pend_in = 1'b1;
               iss_in  = iss_ff + 1'b1;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = paddr_ff;
               freed_in  = freed_new;
               if (mem_rdata == MARK_END || at_last) begin
                  pend_in  = 1'b0;
                  bytes_in = BYTES_W'(freed_new) * BYTES_W'(chunk_size);
                  if (idx_ext < hint_ff) begin
                     hint_in = idx_ext;
                  end
                  state_in = S_ACCUM;
               end
            end
         end
         S_ACCUM: begin
            if (op_ff == OP_ALLOC) begin
               used_in = used_ff + DATA_W'(bytes_ff);
            end else if (DATA_W'(bytes_ff) > used_ff) begin
               used_in = '0;
            end else begin
               used_in = used_ff - DATA_W'(bytes_ff);
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_granted_in = (status_ff == ST_OK) ? granted_ff : '0;
               rsp_used_in    = used_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_valid && (csr_index == CSR_REGION || csr_index == CSR_CHUNK)) begin
         if (csr_index == CSR_REGION) begin
            region_in = csr_wdata;
         end else begin
            chunk_in = csr_wdata[CHUNK_W-1:0];
         end
         used_in     = '0;
         hint_in     = '0;
         wptr_in     = '0;
         sweep_op_in = 1'b0;
         state_in    = S_SWEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         region_ff    <= REGION_RESET;
         chunk_ff     <= CHUNK_RESET;
         nchunk_ff    <= CNT_W'(MAX_CHUNKS);
         hint_ff      <= '0;
         used_ff      <= '0;
         wptr_ff      <= '0;
         sweep_op_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         region_ff    <= region_in;
         chunk_ff     <= chunk_in;
         nchunk_ff    <= nchunk_in;
         hint_ff      <= hint_in;
         used_ff      <= used_in;
         wptr_ff      <= wptr_in;
         sweep_op_ff  <= sweep_op_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      status_ff      <= status_in;
      granted_ff     <= granted_in;
      need_ff        <= need_in;
      begin_ff       <= begin_in;
      run_ff         <= run_in;
      iss_ff         <= iss_in;
      paddr_ff       <= paddr_in;
      last_ff        <= last_in;
      freed_ff       <= freed_in;
      idx_ff         <= idx_in;
      bytes_ff       <= bytes_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_used_ff    <= rsp_used_in;
   end

   assign req_ready          = state_ff == S_IDLE;
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_offset = rsp_granted_ff;
   assign rsp_used_bytes     = rsp_used_ff;
   assign rsp_region_empty   = rsp_used_ff == '0;
endmodule

/* hw/rtl/cmff_ram.sv */
// ----------------------------------------------------------------------------
// cmff_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmff_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/cmff_div.sv */
// ----------------------------------------------------------------------------
// cmff_div
// restoring divider, one quotient bit per cycle, for byte to chunk conversion
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmff_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cmff_pkg::DATA_W-1:0]  dividend,
   input  logic [cmff_pkg::CHUNK_W-1:0] divisor,
   output cmff_pkg::div_res_type       res
);
   import cmff_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [CHUNK_W-1:0]   rem_ff, rem_in;
   logic [CHUNK_W:0]     shifted;
   logic [CHUNK_W:0]     diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = shifted - {1'b0, divisor};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in = diff[CHUNK_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[CHUNK_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign res.done      = done_ff;
   assign res.quotient  = quo_ff;
   assign res.remainder = rem_ff;
endmodule

/* hw/rtl/cmff_checker.sv */
// ----------------------------------------------------------------------------
// cmff_checker
// port-level checks for the chunk map allocator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chunk_map_first_fit_allocator_macros.svh"

module cmff_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cmff_pkg::STATUS_W-1:0]  rsp_status,
   input logic [cmff_pkg::DATA_W-1:0]    rsp_granted_offset,
   input logic [cmff_pkg::DATA_W-1:0]    rsp_used_bytes,
   input logic                          rsp_region_empty
);
   import cmff_pkg::*;

   // map is swept after reset before any request
   `CMFF_ASSERT_NEXT_ALWAYS(a_reset_sweep, reset, !req_ready)
   // a stalled beat holds
   `CMFF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_used_bytes))
   // empty flag follows the byte count
   `CMFF_ASSERT_IMPL(a_empty_flag, rsp_valid,
      rsp_region_empty == (rsp_used_bytes == '0))
   // only a successful beat carries an offset
   `CMFF_ASSERT_IMPL(a_grant_zero, rsp_valid && rsp_status != ST_OK,
      rsp_granted_offset == '0)
   // accepted request drops req_ready in the next cycle
   `CMFF_ASSERT_NEXT(a_one_busy, req_valid && req_ready, !req_ready)
endmodule

bind chunk_map_first_fit_allocator cmff_checker u_cmff_checker (.*);
